// ----- hdl/ale_pkg.sv -----
// shared types and constants of the array list engine
// no dependencies; used by the interfaces, the core and the top level
package ale_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [FIDX_W-1:0]   found_index;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

// ----- hdl/ale_if.sv -----
// valid/ready channels of the array list engine: command in, result out
// depends on ale_pkg
interface ale_in_if
  import ale_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

interface ale_out_if
  import ale_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [FIDX_W-1:0]      found_index;
  logic [COUNT_W-1:0]     count;

  modport source (output valid, status, found_index, count, input ready);
  modport sink (input valid, status, found_index, count, output ready);
endinterface

// ----- hdl/ale_core.sv -----
// list storage, shared pointer/compare unit and the sequencer that walks it
// depends on ale_pkg
module ale_core
  import ale_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output res_t                      res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_INS_WR
  } state_e;

  typedef enum logic {
    R_BUSY,
    R_DONE
  } phase_e;

  state_e                    state_q, state_d;
  phase_e                    phase_q, phase_d;
  cmd_e                      cmd_q, cmd_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic [IDX_W-1:0]          ptr_q, ptr_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  status_e                   status_q, status_d;

  logic [VALUE_W-1:0]        mem_q [CAPACITY];
  logic [VALUE_W-1:0]        rdata_q;
  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_W-1:0]        mem_wdata;

  logic [CNT_W-1:0]          ptr_inc, cnt_dec;
  logic [IDX_W-1:0]          ptr_dec;
  logic                      full;

  // shared pointer arithmetic
  assign ptr_inc = CNT_W'(ptr_q) + CNT_W'(1);
  assign ptr_dec = ptr_q - IDX_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);
  assign full    = (cnt_q == CNT_W'(CAPACITY));

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    value_d   = value_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q;
    mem_raddr = ptr_q;
    mem_wdata = rdata_q;
    in_ready_o = 1'b0;

    if (phase_q == R_DONE) begin
      if (res_ready_i) begin
        phase_d = R_BUSY;
        state_d = S_IDLE;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_d    = cmd_e'(cmd_i);
            value_d  = value_i;
            idx_d    = '0;
            ptr_d    = '0;
            status_d = ST_OK;
            unique case (cmd_e'(cmd_i))
              CMD_APPEND: begin
                pos_d = IDX_W'(cnt_q);
                if (full) begin
                  status_d = ST_FULL;
                  phase_d  = R_DONE;
                end else begin
                  state_d = S_INS_WR;
                end
              end
              CMD_DELETE, CMD_SEARCH: begin
                if (cnt_q == '0) begin
                  status_d = ST_NOT_FOUND;
                  phase_d  = R_DONE;
                end else begin
                  state_d = S_SCAN_RD;
                end
              end
              CMD_INSERT: begin
                pos_d = IDX_W'(position_i);
                ptr_d = IDX_W'(cnt_q);
                if (full) begin
                  status_d = ST_FULL;
                  phase_d  = R_DONE;
                end else if (CMP_W'(position_i) > CMP_W'(cnt_q)) begin
                  status_d = ST_BAD_POS;
                  phase_d  = R_DONE;
                end else if (CMP_W'(position_i) == CMP_W'(cnt_q)) begin
                  state_d = S_INS_WR;
                end else begin
                  state_d = S_SHU_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN_RD: begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          state_d   = S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rdata_q == value_q) begin
            idx_d = ptr_q;
            if (cmd_q == CMD_DELETE) begin
              if (ptr_inc < cnt_q) begin
                state_d = S_SHD_RD;
              end else begin
                cnt_d   = cnt_dec;
                phase_d = R_DONE;
              end
            end else begin
              phase_d = R_DONE;
            end
          end else if (ptr_inc >= cnt_q) begin
            status_d = ST_NOT_FOUND;
            phase_d  = R_DONE;
          end else begin
            ptr_d   = IDX_W'(ptr_inc);
            state_d = S_SCAN_RD;
          end
        end
        // delete: pull later entries down one word at a time, a read state then a write state
        S_SHD_RD: begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(ptr_inc);
          state_d   = S_SHD_WR;
        end
        S_SHD_WR: begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q;
          ptr_d     = IDX_W'(ptr_inc);
          if (ptr_inc < cnt_dec) begin
            state_d = S_SHD_RD;
          end else begin
            cnt_d   = cnt_dec;
            phase_d = R_DONE;
          end
        end
        // insert: push entries from the end up to the gap
        S_SHU_RD: begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec;
          state_d   = S_SHU_WR;
        end
        S_SHU_WR: begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q;
          ptr_d     = ptr_dec;
          state_d   = (ptr_dec == pos_q) ? S_INS_WR : S_SHU_RD;
        end
        S_INS_WR: begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = value_q;
          cnt_d     = cnt_q + CNT_W'(1);
          phase_d   = R_DONE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= R_BUSY;
      cnt_q    <= '0;
      cmd_q    <= CMD_APPEND;
      status_q <= ST_OK;
      value_q  <= '0;
      pos_q    <= '0;
      ptr_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
      value_q  <= value_d;
      pos_q    <= pos_d;
      ptr_q    <= ptr_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign res_valid_o       = (phase_q == R_DONE);
  assign res_o.status      = status_q;
  assign res_o.found_index = FIDX_W'(idx_q);
  assign res_o.count       = COUNT_W'(cnt_q);

endmodule

// ----- hdl/array_list_engine_unit.sv -----
// array list engine top level: sequencer core plus output word register
// append writes the new entry; search and delete scan the list entry by entry;
// delete and insert then shift each later entry with one read and one write
// one command at a time, set by the word-by-word walk of the list memory
// reset: the count clears to zero; list contents are undefined until written
module array_list_engine_unit
  import ale_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ale_in_if.sink   in_i,
  ale_out_if.source out_o
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_res_q;

  ale_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cmd_i       (in_i.cmd),
    .value_i     (in_i.value),
    .position_i  (in_i.position),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output word register frees the core while a result waits
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_res_q.status;
  assign out_o.found_index = out_res_q.found_index;
  assign out_o.count       = out_res_q.count;

endmodule

// ----- bench/array_list_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench of array_list_engine_unit: commands go in on one valid/ready channel
// and results are checked against a list model held here; needs ale_pkg and ale_if
module array_list_engine_unit_tb;
  import ale_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned END_CYCLES = 100;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  ale_in_if  cmd_if ();
  ale_out_if res_if ();

  array_list_engine_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // list model
  logic signed [VALUE_W-1:0] list_vals [CAPACITY];
  int unsigned               list_len;
  res_t                      expected_results [$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_gap_max;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_step;
  logic [15:0] stall_bits;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic res_t list_apply(input cmd_e op, input logic signed [VALUE_W-1:0] v,
                                      input logic [POS_W-1:0] pos);
    res_t r;
    int   hit;
    r.status      = ST_OK;
    r.found_index = '0;
    hit           = -1;
    for (int i = 0; i < int'(list_len); i++) begin
      if (hit < 0 && list_vals[i] == v) hit = i;
    end
    case (op)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_vals[list_len] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < int'(list_len); i++) list_vals[i] = list_vals[i+1];
          list_len--;
          r.found_index = FIDX_W'(hit);
        end
      end
      CMD_SEARCH: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found_index = FIDX_W'(hit);
      end
      default: begin
        // full takes priority over a bad position
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (int i = int'(list_len); i > int'(pos); i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = v;
          list_len++;
        end
      end
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // sends one command word, with random gaps between bursts
  task automatic send_cmd(input cmd_e op, input logic signed [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if (send_gap_max > 0) gap = $urandom_range(send_gap_max, 1);
    end
    burst_left--;
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid    = 1'b1;
    cmd_if.cmd      = op;
    cmd_if.value    = v;
    cmd_if.position = pos;
    do @(posedge clk_i); while (!cmd_if.ready);
    expected_results.push_back(list_apply(op, v, pos));
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    cmd_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // receiver stalls on a rotating random pattern; stall_mode 0 never stalls, 1 stalls less often than 2
  always @(negedge clk_i) begin
    if (stall_step == 0) begin
      stall_bits = 16'($urandom);
      if (stall_mode == 1) stall_bits &= 16'($urandom);
      if (stall_mode == 0) stall_bits = '0;
    end
    res_if.ready = !stall_bits[stall_step];
    stall_step   = (stall_step + 1) % 16;
  end

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result word status=%0d idx=%0d count=%0d",
                               res_if.status, res_if.found_index, res_if.count));
      end else begin
        exp_res = expected_results.pop_front();
        if (res_if.status !== exp_res.status)
          report_error($sformatf("status %0d, expected %0d", res_if.status, exp_res.status));
        if (res_if.found_index !== exp_res.found_index)
          report_error($sformatf("found_index %0d, expected %0d",
                                 res_if.found_index, exp_res.found_index));
        if (res_if.count !== exp_res.count)
          report_error($sformatf("count %0d, expected %0d", res_if.count, exp_res.count));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("array_list_engine_unit_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_SEARCH, 32'sd5, '0);
    send_cmd(CMD_DELETE, 32'sd5, '0);
    send_cmd(CMD_INSERT, 32'sd9, 4'd1);
    send_cmd(CMD_INSERT, 32'sd9, 4'd15);
  endtask

  task automatic test_order_and_extremes();
    send_cmd(CMD_INSERT, VAL_MIN, 4'd0);
    send_cmd(CMD_APPEND, VAL_MAX, 4'd15);
    send_cmd(CMD_INSERT, 32'sd0, 4'd1);
    send_cmd(CMD_APPEND, -32'sd1, '0);
    send_cmd(CMD_APPEND, VAL_MIN, '0);
    send_cmd(CMD_SEARCH, VAL_MIN, '0);
    send_cmd(CMD_DELETE, VAL_MIN, '0);
    send_cmd(CMD_SEARCH, VAL_MIN, '0);
    send_cmd(CMD_INSERT, 32'sh5A5A_A5A5, 4'd4);
  endtask

  task automatic test_fill_and_overflow();
    int unsigned n;
    n = 0;
    // alternate front inserts (longest shift) with appends until full
    while (list_len < CAPACITY) begin
      if (n[0]) send_cmd(CMD_APPEND, $urandom, '0);
      else send_cmd(CMD_INSERT, $urandom, 4'd0);
      n++;
    end
    send_cmd(CMD_APPEND, 32'sd1, '0);
    send_cmd(CMD_INSERT, 32'sd1, 4'd15);
    send_cmd(CMD_SEARCH, list_vals[CAPACITY-1], '0);
    send_cmd(CMD_DELETE, list_vals[CAPACITY-1], '0);
    wait_results_drained();
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (list_len > 0 && roll < 55) return list_vals[$urandom_range(list_len - 1)];
    if (roll < 75) begin
      case ($urandom_range(4))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return -32'sd1;
        default: return $urandom_range(7);
      endcase
    end
    return $urandom;
  endfunction

  // adds make up 30, 50 or 70 percent of commands for fill_bias 0, 1 or 2; delete and search split the rest
  task automatic random_phase(input int unsigned n_items, input int unsigned fill_bias);
    int unsigned roll;
    int unsigned add_wt;
    cmd_e        op;
    logic [POS_W-1:0] pos;
    add_wt = 30 + 20 * fill_bias;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < add_wt) op = roll[0] ? CMD_APPEND : CMD_INSERT;
      else if (roll < add_wt + (100 - add_wt) / 2) op = CMD_DELETE;
      else op = CMD_SEARCH;
      if ($urandom_range(9) < 8) pos = POS_W'($urandom_range((list_len > 15) ? 15 : list_len));
      else pos = POS_W'($urandom_range(15));
      send_cmd(op, pick_value(), pos);
      if ($urandom_range(49) == 0) wait_results_drained();
    end
  endtask

  task automatic test_random_traffic();
    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_gap_max = 0;  stall_mode = 0; end
        1: begin send_gap_max = 3;  stall_mode = 1; end
        2: begin send_gap_max = 12; stall_mode = 0; end
        3: begin send_gap_max = 0;  stall_mode = 2; end
        4: begin send_gap_max = 10; stall_mode = 2; end
        default: begin send_gap_max = 2; stall_mode = 1; end
      endcase
      random_phase(108, ph % 3);
      wait_results_drained();
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = CMD_APPEND;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    res_if.ready    = 1'b0;
    error_count     = 0;
    idle_cycles     = 0;
    list_len        = 0;
    burst_left      = 0;
    send_gap_max    = 4;
    stall_mode      = 1;
    stall_step      = 0;
    stall_bits      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_order_and_extremes();
    test_fill_and_overflow();
    test_random_traffic();

    wait_results_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("array_list_engine_unit_tb: done, clean");
    end else begin
      $display("array_list_engine_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ale_pkg.sv
hdl/ale_if.sv
hdl/ale_core.sv
hdl/array_list_engine_unit.sv
bench/array_list_engine_unit_tb.sv
